>>> sv/wsdf_pkg.sv
// Package for the websocket frame deframer.
// Holds the parse phase type, frame kind codes, opcodes and size defaults.
// No dependencies.
package wsdf_pkg;

   localparam int LENGTH_BITS_DEF = 64;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_KEY,
      PH_PAY
   } phase_type;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_PING   = 2'd1;
   localparam logic [1:0] KIND_CLOSE  = 2'd2;
   localparam logic [1:0] KIND_IGNORE = 2'd3;

   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_LAST_DATA = 4'h2;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   function automatic logic [1:0] kind_of(input logic [3:0] op);
      logic [1:0] k;
      if (op <= OP_LAST_DATA) begin
         k = KIND_DATA;
      end else if (op == OP_PING) begin
         k = KIND_PING;
      end else if (op == OP_CLOSE) begin
         k = KIND_CLOSE;
      end else begin
         k = KIND_IGNORE;
      end
      return k;
   endfunction

endpackage

>>> sv/websocket_frame_deframer.sv
// Receive-side websocket frame deframer, one stream byte per item.
// Depends on wsdf_pkg for the phase type, kind codes and opcodes.
//
// Takes one received byte at a time and gives at most one result per byte, in the
// next cycle, from an output register: the header parse, length count-down and
// unmasking of a byte all happen in the cycle it is accepted, so the rate is one byte
// per cycle whenever the result side keeps up. Header bytes give no result except the
// last header byte of an empty frame, which gives a frame_end result with no data.
// Lengths that overflow LENGTH_BITS saturate. Once a close frame completes, every
// further byte is taken and dropped until reset. Pong replies are not generated here.
module websocket_frame_deframer
   import wsdf_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_valid,
   output logic [1:0] rsp_frame_kind,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_frame_end,
   output logic       rsp_message_done,
   output logic       rsp_closed_flag
);

   phase_type              phase_ff, phase_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   mask_ff, mask_in;
   logic [3:0]             count_ff, count_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             key_idx_ff, key_idx_in;
   logic                   has_data_ff, has_data_in;
   logic                   closed_ff, closed_in;

   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_bvalid_ff, out_bvalid_in;
   logic [1:0]             out_kind_ff, out_kind_in;
   logic [3:0]             out_op_ff, out_op_in;
   logic                   out_end_ff, out_end_in;
   logic                   out_done_ff, out_done_in;
   logic                   out_closed_ff, out_closed_in;

   logic                   accept;
   logic                   emit;
   logic                   last;
   logic                   hdr_done;
   logic                   data_seen;
   logic [1:0]             kind;
   logic [7:0]             key_byte;
   logic [6:0]             len7;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign kind      = kind_of(opcode_ff);
   assign len7      = req_rx_byte[6:0];
   assign key_byte  = 8'(key_ff >> {~key_idx_ff, 3'b000});

   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      opcode_in   = opcode_ff;
      mask_in     = mask_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      key_in      = key_ff;
      key_idx_in  = key_idx_ff;
      has_data_in = has_data_ff;
      closed_in   = closed_ff;
      emit        = 1'b0;
      last        = 1'b0;
      hdr_done    = 1'b0;
      data_seen   = has_data_ff;
      out_byte_in = 8'd0;
      out_bvalid_in = 1'b0;

      if (accept && !closed_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = req_rx_byte[7];
               opcode_in = req_rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = req_rx_byte[7];
               if (len7 == LEN_EXT16) begin
                  remain_in = '0;
                  count_in  = EXT16_BYTES;
                  phase_in  = PH_EXT;
               end else if (len7 == LEN_EXT64) begin
                  remain_in = '0;
                  count_in  = EXT64_BYTES;
                  phase_in  = PH_EXT;
               end else begin
                  remain_in = LENGTH_BITS'(len7);
                  if (req_rx_byte[7]) begin
                     phase_in = PH_KEY;
                     count_in = KEY_BYTES;
                     key_in   = '0;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               if (remain_ff[LENGTH_BITS-1 -: 8] != 8'd0) begin
                  remain_in = '1;
               end else begin
                  remain_in = {remain_ff[LENGTH_BITS-9:0], req_rx_byte};
               end
               if (count_ff != 4'd0) begin
                  count_in = count_ff - 4'd1;
               end
               if (count_ff <= 4'd1) begin
                  if (mask_ff) begin
                     phase_in = PH_KEY;
                     count_in = KEY_BYTES;
                     key_in   = '0;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], req_rx_byte};
               if (count_ff != 4'd0) begin
                  count_in = count_ff - 4'd1;
               end
               if (count_ff <= 4'd1) begin
                  hdr_done = 1'b1;
               end
            end
            PH_PAY: begin
               key_idx_in    = key_idx_ff + 2'd1;
               if (kind == KIND_DATA) begin
                  data_seen = 1'b1;
               end
               has_data_in   = data_seen;
               if (remain_ff != '0) begin
                  remain_in = remain_ff - LENGTH_BITS'(1);
               end
               emit          = 1'b1;
               last          = (remain_ff[LENGTH_BITS-1:1] == '0);
               out_bvalid_in = 1'b1;
               out_byte_in   = req_rx_byte ^ (mask_ff ? key_byte : 8'd0);
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         if (hdr_done) begin
            key_idx_in = 2'd0;
            if (remain_in == '0) begin
               emit = 1'b1;
               last = 1'b1;
            end else begin
               phase_in = PH_PAY;
            end
         end
      end

      out_done_in   = 1'b0;
      out_closed_in = 1'b0;
      if (last) begin
         phase_in = PH_HDR0;
         if (kind == KIND_CLOSE) begin
            closed_in     = 1'b1;
            out_closed_in = 1'b1;
         end else if (fin_ff && data_seen) begin
            out_done_in = 1'b1;
            has_data_in = 1'b0;
         end
      end

      out_kind_in = kind;
      out_op_in   = opcode_ff;
      out_end_in  = last;
      if (accept) begin
         out_valid_in = emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         fin_ff       <= 1'b0;
         opcode_ff    <= 4'd0;
         mask_ff      <= 1'b0;
         count_ff     <= 4'd0;
         remain_ff    <= '0;
         key_ff       <= '0;
         key_idx_ff   <= 2'd0;
         has_data_ff  <= 1'b0;
         closed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         key_ff       <= key_in;
         key_idx_ff   <= key_idx_in;
         has_data_ff  <= has_data_in;
         closed_ff    <= closed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_byte_ff   <= out_byte_in;
         out_bvalid_ff <= out_bvalid_in;
         out_kind_ff   <= out_kind_in;
         out_op_ff     <= out_op_in;
         out_end_ff    <= out_end_in;
         out_done_ff   <= out_done_in;
         out_closed_ff <= out_closed_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_byte_valid   = out_bvalid_ff;
   assign rsp_frame_kind   = out_kind_ff;
   assign rsp_frame_opcode = out_op_ff;
   assign rsp_frame_end    = out_end_ff;
   assign rsp_message_done = out_done_ff;
   assign rsp_closed_flag  = out_closed_ff;

endmodule
